// File: sv/assert_macros.svh
// Assertion macros shared by the predictor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: sv/tbp_pkg.sv
// Package with types and constants of the tournament branch predictor.
`timescale 1ns / 1ps
package tbp_pkg;
  localparam int unsigned CounterBits = 2;
  localparam logic [1:0] CtrReset = 2'd1;
  localparam logic [1:0] CtrMax = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_HIST,
    ST_READ_CTR,
    ST_WRITE,
    ST_OUT
  } tbp_state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic read_hist;
    logic read_ctr;
    logic write;
  } tbp_cmd_t;

  typedef struct packed {
    logic clear_done;
  } tbp_status_t;

  function automatic logic [1:0] sat_move(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != CtrMax) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction
endpackage

// File: sv/tbp_branch_if.sv
// Handshake interface that carries one resolved branch.
`timescale 1ns / 1ps
interface tbp_branch_if;
  logic        valid;
  logic        ready;
  logic [31:0] pc;
  logic        outcome;
  modport source (output valid, output pc, output outcome, input ready);
  modport sink (input valid, input pc, input outcome, output ready);
endinterface

// File: sv/tbp_pred_if.sv
// Handshake interface that carries one prediction result.
`timescale 1ns / 1ps
interface tbp_pred_if;
  logic valid;
  logic ready;
  logic prediction;
  logic chose_local;
  modport source (output valid, output prediction, output chose_local, input ready);
  modport sink (input valid, input prediction, input chose_local, output ready);
endinterface

// File: sv/tbp_ctrl.sv
// Controller state machine that sequences clearing, table reads and training.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tbp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tbp_pkg::tbp_cmd_t    cmd,
  input  tbp_pkg::tbp_status_t status
);
  import tbp_pkg::*;

  tbp_state_t state;
  tbp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // The next request is accepted only in the cycle after the result is taken.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_READ_HIST;
        end
      end
      ST_READ_HIST: begin
        cmd.read_hist = 1'b1;
        state_next = ST_READ_CTR;
      end
      ST_READ_CTR: begin
        cmd.read_ctr = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  `ASSERT_IMPL(a_write_follows_read, clk, rst, (state == ST_WRITE) |-> $past(state == ST_READ_CTR), "write without counter read")
  `ASSERT_IMPL(a_no_out_during_clear, clk, rst, (state == ST_CLEAR) |-> !out_valid && !in_ready, "handshake during clear")
  `ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) |-> (state == ST_CLEAR), "reset did not start clear")
endmodule

// File: sv/tbp_datapath.sv
// Datapath with history and counter tables, prediction and training logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tbp_datapath #(
  parameter int unsigned LOCAL_HIST_BITS  = 10,
  parameter int unsigned GLOBAL_HIST_BITS = 9,
  parameter int unsigned PC_INDEX_BITS    = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  tbp_pkg::tbp_cmd_t    cmd,
  output tbp_pkg::tbp_status_t status,
  input  logic [31:0]         pc,
  input  logic                outcome,
  output logic                prediction,
  output logic                chose_local
);
  import tbp_pkg::*;

  localparam int unsigned MaxBits =
    (LOCAL_HIST_BITS > GLOBAL_HIST_BITS) ?
      ((LOCAL_HIST_BITS > PC_INDEX_BITS) ? LOCAL_HIST_BITS : PC_INDEX_BITS) :
      ((GLOBAL_HIST_BITS > PC_INDEX_BITS) ? GLOBAL_HIST_BITS : PC_INDEX_BITS);
  localparam int unsigned LhtDepth = 1 << PC_INDEX_BITS;
  localparam int unsigned LctDepth = 1 << LOCAL_HIST_BITS;
  localparam int unsigned GctDepth = 1 << GLOBAL_HIST_BITS;

  logic [LOCAL_HIST_BITS-1:0] lht [LhtDepth];
  logic [CounterBits-1:0]     lct [LctDepth];
  logic [CounterBits-1:0]     gct [GctDepth];
  logic [CounterBits-1:0]     cct [GctDepth];

  logic [MaxBits:0]            clr_idx;
  logic [GLOBAL_HIST_BITS-1:0] ghist;
  logic [PC_INDEX_BITS-1:0]    slot;
  logic                        taken;
  logic [LOCAL_HIST_BITS-1:0]  lhist;
  logic [CounterBits-1:0]      lctr;
  logic [CounterBits-1:0]      gctr;
  logic [CounterBits-1:0]      cctr;
  logic                        lpred;
  logic                        gpred;
  logic                        use_local;

  assign status.clear_done = clr_idx[MaxBits];
  assign lpred = lctr[CounterBits-1];
  assign gpred = gctr[CounterBits-1];
  assign use_local = cctr[CounterBits-1];

  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (cmd.clear && !clr_idx[MaxBits]) clr_idx <= clr_idx + 1'b1;
  end

  // Clearing pass sweeps every table in parallel, one entry per cycle.
  always_ff @(posedge clk) begin
    if (cmd.clear && !clr_idx[MaxBits]) begin
      if (clr_idx < (MaxBits+1)'(LhtDepth)) lht[clr_idx[PC_INDEX_BITS-1:0]] <= '0;
      if (clr_idx < (MaxBits+1)'(LctDepth)) lct[clr_idx[LOCAL_HIST_BITS-1:0]] <= CtrReset;
      if (clr_idx < (MaxBits+1)'(GctDepth)) begin
        gct[clr_idx[GLOBAL_HIST_BITS-1:0]] <= CtrReset;
        cct[clr_idx[GLOBAL_HIST_BITS-1:0]] <= CtrReset;
      end
    end else if (cmd.write) begin
      lht[slot] <= LOCAL_HIST_BITS'({lhist, taken});
      lct[lhist] <= sat_move(lctr, taken);
      gct[ghist] <= sat_move(gctr, taken);
      if (lpred == taken && gpred != taken) cct[ghist] <= sat_move(cctr, 1'b1);
      else if (lpred != taken && gpred == taken) cct[ghist] <= sat_move(cctr, 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot <= pc[PC_INDEX_BITS-1:0];
      taken <= outcome;
    end
    if (cmd.read_hist) lhist <= lht[slot];
    if (cmd.read_ctr) begin
      lctr <= lct[lhist];
      gctr <= gct[ghist];
      cctr <= cct[ghist];
    end
    if (cmd.write) begin
      prediction <= use_local ? lpred : gpred;
      chose_local <= use_local;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ghist <= '0;
    else if (cmd.write) ghist <= GLOBAL_HIST_BITS'({ghist, taken});
  end

  `ASSERT_IMPL(a_no_train_in_clear, clk, rst, cmd.write |-> !cmd.clear && status.clear_done, "training before clear finished")
  `ASSERT_IMPL(a_ghist_shift, clk, rst, $past(cmd.write) |-> (ghist[0] == $past(taken)), "global history shift wrong")
  `ASSERT_IMPL(a_ghist_hold, clk, rst, (!$past(cmd.write) && !$past(rst)) |-> $stable(ghist), "global history moved without training")
endmodule

// File: sv/tournament_branch_predictor_top.sv
// Top level of the tournament branch predictor.
// Usage: the branch channel carries one resolved branch per request (pc and
// outcome); the prediction channel returns one result per request giving the
// prediction made before training and whether the local side was chosen.
// Each request passes through capture, local history read, counter reads,
// training write, and result hold. The result is registered at the training
// write and is valid in the result-hold state that follows.
// The next request is accepted in the cycle after the result is taken, so a
// new request is not taken before the last is through; throughput is set
// by the chain of dependent table reads through single-ported memories.
// After reset a clearing pass writes one entry of every table per cycle until
// each table is covered; no request is accepted during it.
// If the receiver stalls, the result holds steady and no new request is
// accepted until it is taken.
`timescale 1ns / 1ps
module tournament_branch_predictor_top #(
  parameter int unsigned LOCAL_HIST_BITS  = 10,
  parameter int unsigned GLOBAL_HIST_BITS = 9,
  parameter int unsigned PC_INDEX_BITS    = 10
) (
  input logic         clk,
  input logic         rst,
  tbp_branch_if.sink  branch,
  tbp_pred_if.source  pred
);
  import tbp_pkg::*;

  tbp_cmd_t    cmd;
  tbp_status_t status;

  tbp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(branch.valid), .in_ready(branch.ready),
    .out_valid(pred.valid), .out_ready(pred.ready),
    .cmd(cmd), .status(status)
  );

  tbp_datapath #(
    .LOCAL_HIST_BITS(LOCAL_HIST_BITS),
    .GLOBAL_HIST_BITS(GLOBAL_HIST_BITS),
    .PC_INDEX_BITS(PC_INDEX_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .pc(branch.pc), .outcome(branch.outcome),
    .prediction(pred.prediction), .chose_local(pred.chose_local)
  );
endmodule
